>>> rtl/core/vpa_pkg.sv
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared constants, codes and types of the variable-partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

  localparam int unsigned MemBytes    = 65536;
  localparam int unsigned MaxSegments = 64;

  localparam int unsigned SizeW  = $clog2(MemBytes + 1);
  localparam int unsigned OffW   = $clog2(MemBytes);
  localparam int unsigned IdxW   = $clog2(MaxSegments);
  localparam int unsigned CntW   = $clog2(MaxSegments + 1);
  localparam int unsigned EntryW = OffW + SizeW + 1;

  localparam logic [2:0] StatusOk      = 3'd0;
  localparam logic [2:0] StatusZero    = 3'd1;
  localparam logic [2:0] StatusNoFit   = 3'd2;
  localparam logic [2:0] StatusNoAlloc = 3'd3;
  localparam logic [2:0] StatusFull    = 3'd4;

  localparam logic CmdAlloc   = 1'b0;
  localparam logic CmdRelease = 1'b1;

  typedef struct packed {
    logic [OffW-1:0]  start;
    logic [SizeW-1:0] length;
    logic             is_free;
  } seg_t;

endpackage

>>> rtl/core/vpa_ram.sv
// ----------------------------------------------------------------------------
// vpa_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module vpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> rtl/core/variable_partition_allocator.sv
// ----------------------------------------------------------------------------
// variable_partition_allocator
// Segment-table allocator with first/best fit and coalescing on release.
// ----------------------------------------------------------------------------
// The segment table lives in one single-port RAM, and every command walks it
// one access per cycle. The search reads and checks each segment examined,
// the shift reads and writes each moved entry, and one or two writes store the
// result. The worst case is a best-fit split of the lowest segment of a
// 63-entry table. A zero-size allocation request goes from idle straight to
// the done state. busy_o stays high until the result appears for one cycle on
// done_o. The receiver cannot stall results.
module variable_partition_allocator
  import vpa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             cmd_i,
  input  logic [16:0]      req_size_i,
  input  logic [15:0]      release_offset_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [15:0]      block_offset_o,
  output logic [6:0]       probes_o,
  output logic [16:0]      free_bytes_o,
  output logic [16:0]      alloc_bytes_o,
  output logic [6:0]       free_blocks_o,
  output logic [6:0]       alloc_blocks_o
);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_SRD, ST_SCHK, ST_GRD, ST_GCHK,
    ST_MRD, ST_MWR, ST_FIN1, ST_FIN2, ST_DONE
  } state_e;

  state_e           state_q;
  logic             strat_q;
  logic             cmd_q;
  logic [SizeW-1:0] size_q;
  logic [OffW-1:0]  roff_q;
  logic [CntW-1:0]  seg_cnt_q, i_q, pick_q, probes_q;
  logic             found_q;
  logic [SizeW-1:0] best_q;
  logic [SizeW-1:0] ftot_q, atot_q;
  logic [CntW-1:0]  fcnt_q, acnt_q;
  seg_t             cur_q, prv_q, nxt_q;  // pick, neighbors
  logic             pf_q;                 // prev free
  logic [CntW-1:0]  j_q, jend_q, k_q;     // shift cursor
  logic             up_q;                 // shift toward higher index
  logic [2:0]       st_q;
  logic [OffW-1:0]  boff_q;
  logic [1:0]       fin_q;

  logic             we;
  logic [IdxW-1:0]  addr;
  seg_t             wdata, rdata;
  logic             next_free;
  logic [CntW-1:0]  rel_k;

  vpa_ram #(.Width(EntryW), .Depth(MaxSegments)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  // Release resolution; rdata holds entry pick+1 when it exists.
  assign next_free = (pick_q + 1'b1 != seg_cnt_q) && rdata.is_free;
  assign rel_k     = CntW'(pf_q) + CntW'(next_free);

  // Combinational memory port control.
  always_comb begin
    we    = 1'b0;
    addr  = i_q[IdxW-1:0];
    wdata = cur_q;
    unique case (state_q)
      ST_INIT: begin
        we = 1'b1;
        addr = '0;
        wdata = '{start: '0, length: SizeW'(MemBytes), is_free: 1'b1};
      end
      ST_MRD:  addr = IdxW'(up_q ? j_q - 1'b1 : j_q + k_q);
      ST_MWR: begin
        we = 1'b1; addr = j_q[IdxW-1:0]; wdata = rdata;
      end
      ST_FIN1: begin
        we = 1'b1; addr = pick_q[IdxW-1:0]; wdata = cur_q;
      end
      ST_FIN2: begin
        we = 1'b1; addr = pick_q[IdxW-1:0] + 1'b1; wdata = nxt_q;
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      strat_q <= 1'b0;
      cmd_q <= CmdAlloc;
      size_q <= '0;
      roff_q <= '0;
      seg_cnt_q <= CntW'(1);
      i_q <= '0;
      pick_q <= '0;
      probes_q <= '0;
      found_q <= 1'b0;
      best_q <= '0;
      ftot_q <= SizeW'(MemBytes);
      atot_q <= '0;
      fcnt_q <= CntW'(1);
      acnt_q <= '0;
      cur_q <= '0;
      prv_q <= '0;
      nxt_q <= '0;
      pf_q <= 1'b0;
      j_q <= '0;
      jend_q <= '0;
      k_q <= '0;
      up_q <= 1'b0;
      st_q <= StatusOk;
      boff_q <= '0;
      fin_q <= '0;
      done_o <= 1'b0;
      status_o <= '0;
      block_offset_o <= '0;
      probes_o <= '0;
      free_bytes_o <= '0;
      alloc_bytes_o <= '0;
      free_blocks_o <= '0;
      alloc_blocks_o <= '0;
    end else begin
      done_o <= 1'b0;
      if (cfg_we_i) begin
        strat_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_INIT: state_q <= ST_IDLE;
        ST_IDLE: begin
          if (start_i) begin
            cmd_q <= cmd_i;
            size_q <= req_size_i;
            roff_q <= release_offset_i;
            i_q <= '0;
            probes_q <= '0;
            found_q <= 1'b0;
            boff_q <= '0;
            if (cmd_i == CmdAlloc && req_size_i == '0) begin
              st_q <= StatusZero;
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_SRD;
            end
          end
        end
        ST_SRD: state_q <= ST_SCHK;  // read of entry i_q issued
        ST_SCHK: begin
          if (cmd_q == CmdAlloc) begin
            if (rdata.is_free && rdata.length >= size_q &&
                (!strat_q || !found_q || (rdata.length - size_q) < best_q)) begin
              pick_q <= i_q;
              cur_q <= rdata;
              best_q <= rdata.length - size_q;
              found_q <= 1'b1;
            end
            if (rdata.is_free && rdata.length >= size_q && !strat_q) begin
              i_q <= i_q;
              state_q <= ST_GRD;
            end else begin
              probes_q <= probes_q + 1'b1;
              if (i_q + 1'b1 == seg_cnt_q) begin
                state_q <= ST_GRD;
              end else begin
                i_q <= i_q + 1'b1;
                state_q <= ST_SRD;
              end
            end
          end else begin
            if (!rdata.is_free && rdata.start == roff_q) begin
              pick_q <= i_q;
              cur_q <= rdata;
              found_q <= 1'b1;
              pf_q <= (i_q != '0) && prv_q.is_free;
              i_q <= i_q + 1'b1;
              if (i_q + 1'b1 == seg_cnt_q) begin
                state_q <= ST_GCHK;
              end else begin
                state_q <= ST_GRD;
              end
            end else if (i_q + 1'b1 == seg_cnt_q) begin
              st_q <= StatusNoAlloc;
              state_q <= ST_DONE;
            end else begin
              prv_q <= rdata;
              i_q <= i_q + 1'b1;
              state_q <= ST_SRD;
            end
          end
        end
        ST_GRD: begin
          if (cmd_q == CmdAlloc) begin
            if (!found_q) begin
              st_q <= StatusNoFit;
              state_q <= ST_DONE;
            end else if (cur_q.length == size_q) begin
              cur_q.is_free <= 1'b0;
              fcnt_q <= fcnt_q - 1'b1;
              acnt_q <= acnt_q + 1'b1;
              ftot_q <= ftot_q - size_q;
              atot_q <= atot_q + size_q;
              boff_q <= cur_q.start;
              st_q <= StatusOk;
              fin_q <= 2'd1;
              state_q <= ST_FIN1;
            end else if (seg_cnt_q == CntW'(MaxSegments)) begin
              st_q <= StatusFull;
              state_q <= ST_DONE;
            end else begin
              nxt_q <= '{start: cur_q.start + size_q[OffW-1:0],
                         length: cur_q.length - size_q, is_free: 1'b1};
              cur_q.length <= size_q;
              cur_q.is_free <= 1'b0;
              acnt_q <= acnt_q + 1'b1;
              ftot_q <= ftot_q - size_q;
              atot_q <= atot_q + size_q;
              boff_q <= cur_q.start;
              st_q <= StatusOk;
              seg_cnt_q <= seg_cnt_q + 1'b1;
              fin_q <= 2'd2;
              // Shift entries pick+1 .. count-1 up by one, top first.
              up_q <= 1'b1;
              k_q <= CntW'(1);
              j_q <= seg_cnt_q;
              jend_q <= pick_q + 1'b1;
              if (seg_cnt_q == pick_q + 1'b1) begin
                state_q <= ST_FIN1;
              end else begin
                state_q <= ST_MRD;
              end
            end
          end else begin
            state_q <= ST_GCHK;  // reads next entry of the release
          end
        end
        ST_GCHK: begin
          acnt_q <= acnt_q - 1'b1;
          ftot_q <= ftot_q + cur_q.length;
          atot_q <= atot_q - cur_q.length;
          st_q <= StatusOk;
          if (pf_q && next_free) begin
            fcnt_q <= fcnt_q - 1'b1;
          end else if (!pf_q && !next_free) begin
            fcnt_q <= fcnt_q + 1'b1;
          end
          fin_q <= 2'd1;
          if (pf_q) begin
            cur_q <= '{start: prv_q.start,
                       length: prv_q.length + cur_q.length
                               + (next_free ? rdata.length : '0),
                       is_free: 1'b1};
            pick_q <= pick_q - 1'b1;
          end else begin
            cur_q <= '{start: cur_q.start,
                       length: cur_q.length + (next_free ? rdata.length : '0),
                       is_free: 1'b1};
          end
          // Remove rel_k entries above the merged one, low first.
          up_q <= 1'b0;
          k_q <= rel_k;
          j_q <= pick_q + CntW'(!pf_q);
          jend_q <= seg_cnt_q - rel_k;
          seg_cnt_q <= seg_cnt_q - rel_k;
          if (rel_k == '0 || pick_q + CntW'(!pf_q) == seg_cnt_q - rel_k) begin
            state_q <= ST_FIN1;
          end else begin
            state_q <= ST_MRD;
          end
        end
        ST_MRD: state_q <= ST_MWR;
        ST_MWR: begin
          if (up_q) begin
            if (j_q - 1'b1 == jend_q) begin
              state_q <= ST_FIN1;
            end else begin
              j_q <= j_q - 1'b1;
              state_q <= ST_MRD;
            end
          end else begin
            if (j_q + 1'b1 == jend_q) begin
              state_q <= ST_FIN1;
            end else begin
              j_q <= j_q + 1'b1;
              state_q <= ST_MRD;
            end
          end
        end
        ST_FIN1: state_q <= (fin_q == 2'd2) ? ST_FIN2 : ST_DONE;
        ST_FIN2: state_q <= ST_DONE;
        ST_DONE: begin
          done_o <= 1'b1;
          status_o <= st_q;
          block_offset_o <= (st_q == StatusOk && cmd_q == CmdAlloc) ? boff_q : '0;
          probes_o <= (cmd_q == CmdAlloc && st_q != StatusZero) ? probes_q : '0;
          free_bytes_o <= ftot_q;
          alloc_bytes_o <= atot_q;
          free_blocks_o <= fcnt_q;
          alloc_blocks_o <= acnt_q;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (free_bytes_o + alloc_bytes_o == SizeW'(MemBytes)))
    else $error("byte totals do not cover memory");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_cnt_q <= CntW'(MaxSegments))
    else $error("segment count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o != StatusOk || probes_o <= seg_cnt_q))
    else $error("probe count beyond table");

endmodule
